FILE: rtl/core/epoch_seconds_to_calendar_defines.svh
// Assertion macros for the epoch to calendar converter.
`ifndef EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define ESC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition that must never be true outside reset.
`define ESC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: rtl/core/esc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch converter package
// Widths, reciprocal constants and the month start table shared by the
// pipeline stages of the epoch to calendar converter.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int SECS_W  = 32;
  localparam int DAYS_W  = 16;
  localparam int TOD_W   = 17;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DOM_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int WDAY_W  = 3;
  localparam int DOY_W   = 9;

  // Seconds per day is 128 * 675; the low 7 bits pass straight through.
  localparam int         DAY_SHIFT = 7;
  localparam logic [9:0] DAY_DIV   = 10'd675;
  localparam logic [25:0] DAY_RECIP = 26'd50903316;  // floor(2^35 / 675)
  localparam int         DAY_RK    = 35;

  // Four-year cycles counted from 1968-01-01.
  localparam logic [15:0] CYC_DAYS   = 16'd1461;
  localparam logic [10:0] CYC_RECIP  = 11'd1435;     // floor(2^21 / 1461)
  localparam int          CYC_RK     = 21;
  localparam logic [15:0] BASE_OFS   = 16'd731;      // days 1968-01-01 to 1970-01-01
  localparam logic [15:0] DAY_2100_MAR = 16'd47541;  // 2100-03-01 as days since epoch
  localparam logic [11:0] CYC_YEAR0  = 12'd1968;

  // Weekday: 1970-01-01 was a Thursday.
  localparam logic [15:0] WDAY_OFS   = 16'd4;
  localparam logic [16:0] WDAY_RECIP = 17'd74898;    // floor(2^19 / 7)
  localparam int          WDAY_RK    = 19;

  // Time of day.
  localparam logic [17:0] HOUR_RECIP = 18'd149130;   // floor(2^29 / 3600)
  localparam int          HOUR_RK    = 29;
  localparam logic [11:0] SECS_HOUR  = 12'd3600;
  localparam logic [12:0] MIN_RECIP  = 13'd4369;     // floor(2^18 / 60)
  localparam int          MIN_RK     = 18;
  localparam logic [5:0]  SECS_MIN   = 6'd60;

  // First day of year of each month, counted from 0.
  function automatic logic [DOY_W-1:0] month_start(input logic leap, input logic [3:0] idx);
    logic [DOY_W-1:0] base;
    begin
      case (idx)
        4'd0:    base = 9'd0;
        4'd1:    base = 9'd31;
        4'd2:    base = 9'd59;
        4'd3:    base = 9'd90;
        4'd4:    base = 9'd120;
        4'd5:    base = 9'd151;
        4'd6:    base = 9'd181;
        4'd7:    base = 9'd212;
        4'd8:    base = 9'd243;
        4'd9:    base = 9'd273;
        4'd10:   base = 9'd304;
        4'd11:   base = 9'd334;
        default: base = 9'd0;
      endcase
      // Months after February move one day later in a leap year.
      if (leap && idx >= 4'd2) begin
        base = base + 9'd1;
      end
      month_start = base;
    end
  endfunction

endpackage

FILE: rtl/core/epoch_seconds_to_calendar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch seconds to calendar
// Converts an unsigned count of seconds since 1970-01-01 00:00:00 into the
// Gregorian date, time of day and weekday.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low; busy
//   stays low, so a request may be issued on every cycle. epoch_seconds is
//   sampled on that edge.
//   Each result appears on year, month, day_of_month, hours, minutes,
//   seconds and weekday for one cycle with strobe high. Results leave in
//   request order.
//   Throughput is one request per cycle: a fixed pipeline of input register,
//   two day split stages and four date and time stages, with reciprocal
//   multiplies and one correction step after each.
//   The receiver cannot stall; it must capture each result while strobe is
//   high.
//   Synchronous reset clears all valid bits, so no strobe follows reset
//   until a new request is taken.
// ----------------------------------------------------------------------------
`include "epoch_seconds_to_calendar_defines.svh"
module epoch_seconds_to_calendar import esc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [SECS_W-1:0]  epoch_seconds,
  output logic               strobe,
  output logic [YEAR_W-1:0]  year,
  output logic [MONTH_W-1:0] month,
  output logic [DOM_W-1:0]   day_of_month,
  output logic [HOUR_W-1:0]  hours,
  output logic [MIN_W-1:0]   minutes,
  output logic [MIN_W-1:0]   seconds,
  output logic [WDAY_W-1:0]  weekday
);

  logic              valid_a;
  logic [SECS_W-1:0] secs_a;
  logic              valid_c;
  logic [DAYS_W-1:0] days_c;
  logic [TOD_W-1:0]  tod_c;

  // The pipeline accepts a request on every cycle.
  assign busy = 1'b0;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else begin
      valid_a <= start && !busy;
    end
    secs_a <= epoch_seconds;
  end

  esc_day_split u_day_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid_a),
    .secs      (secs_a),
    .out_valid (valid_c),
    .days      (days_c),
    .tod       (tod_c)
  );

  esc_date u_date (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (valid_c),
    .days         (days_c),
    .out_valid    (strobe),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .weekday      (weekday)
  );

  esc_time u_time (
    .clk     (clk),
    .tod     (tod_c),
    .hours   (hours),
    .minutes (minutes),
    .seconds (seconds)
  );

  // Checks on the result channel.
  `ESC_ASSERT_IMPL(a_strobe_follows_request, strobe, $past(start && !busy, 7), "strobe without request")
  `ESC_ASSERT_IMPL(a_date_range, strobe, month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1 && year >= 12'd1970, "date out of range")
  `ESC_ASSERT_IMPL(a_time_range, strobe, hours < 5'd24 && minutes < 6'd60 && seconds < 6'd60 && weekday < 3'd7, "time out of range")
  `ESC_ASSERT_NEVER(a_busy_low, busy, "busy raised")

endmodule

FILE: rtl/core/esc_day_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Day split
// Two stages that divide the second count by 86400 into whole days and the
// second of the day, using a reciprocal multiply and one correction step.
// ----------------------------------------------------------------------------
module esc_day_split import esc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [SECS_W-1:0] secs,
  output logic              out_valid,
  output logic [DAYS_W-1:0] days,
  output logic [TOD_W-1:0]  tod
);

  localparam int X_W    = SECS_W - DAY_SHIFT;
  localparam int PROD_W = X_W + 26;

  logic              valid_b;
  logic [X_W-1:0]    x_b;
  logic [DAY_SHIFT-1:0] lo_b;
  logic [PROD_W-1:0] prod_b;

  logic [DAYS_W-1:0] q0;
  logic [X_W-1:0]    qm;
  logic [X_W-1:0]    r0;
  logic [DAYS_W-1:0] q_next;
  logic [9:0]        r_next;

  // Reciprocal product of the second count over 128.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
    end else begin
      valid_b <= in_valid;
    end
    x_b    <= secs[SECS_W-1:DAY_SHIFT];
    lo_b   <= secs[DAY_SHIFT-1:0];
    prod_b <= PROD_W'(secs[SECS_W-1:DAY_SHIFT]) * PROD_W'(DAY_RECIP);
  end

  // The estimate is low by at most one; one compare and subtract fixes it.
  always_comb begin
    q0 = prod_b[DAY_RK +: DAYS_W];
    qm = X_W'(q0) * X_W'(DAY_DIV);
    r0 = x_b - qm;
    if (r0 >= X_W'(DAY_DIV)) begin
      q_next = q0 + 16'd1;
      r_next = 10'(r0 - X_W'(DAY_DIV));
    end else begin
      q_next = q0;
      r_next = 10'(r0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid_b;
    end
    days <= q_next;
    tod  <= {r_next, lo_b};
  end

endmodule

FILE: rtl/core/esc_date.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date stages
// Four stages that turn the day count into year, month, day of month and
// weekday through four-year cycles counted from 1968.
// ----------------------------------------------------------------------------
module esc_date import esc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [DAYS_W-1:0]  days,
  output logic               out_valid,
  output logic [YEAR_W-1:0]  year,
  output logic [MONTH_W-1:0] month,
  output logic [DOM_W-1:0]   day_of_month,
  output logic [WDAY_W-1:0]  weekday
);

  localparam int CP_W = DAYS_W + 11;
  localparam int WP_W = DAYS_W + 17;

  // Stage D
  logic              valid_d;
  logic [DAYS_W-1:0] d_d;
  logic [DAYS_W-1:0] w_d;
  logic [CP_W-1:0]   cprod_d;
  logic [WP_W-1:0]   wprod_d;
  logic [DAYS_W-1:0] d_adj;
  logic [DAYS_W-1:0] w_x;

  // Stage E
  logic              valid_e;
  logic [5:0]        cyc_e;
  logic [10:0]       crem_e;
  logic [WDAY_W-1:0] wday_e;
  logic [5:0]        cq0;
  logic [DAYS_W-1:0] cr0;
  logic [5:0]        cyc_next;
  logic [10:0]       crem_next;
  logic [13:0]       wq0;
  logic [DAYS_W-1:0] wr0;
  logic [WDAY_W-1:0] wday_next;

  // Stage F
  logic              valid_f;
  logic [YEAR_W-1:0] year_f;
  logic              leap_f;
  logic [DOY_W-1:0]  doy_f;
  logic [WDAY_W-1:0] wday_f;
  logic [1:0]        yo;
  logic [DOY_W-1:0]  doy_next;

  // Stage G
  logic [3:0]        mi;
  logic [DOY_W-1:0]  dom_full;

  // A phantom February 29 in 2100 lets the plain four-year rule hold after it.
  always_comb begin
    d_adj = days + BASE_OFS + ((days >= DAY_2100_MAR) ? 16'd1 : 16'd0);
    w_x   = days + WDAY_OFS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_d <= 1'b0;
    end else begin
      valid_d <= in_valid;
    end
    d_d     <= d_adj;
    w_d     <= w_x;
    cprod_d <= CP_W'(d_adj) * CP_W'(CYC_RECIP);
    wprod_d <= WP_W'(w_x) * WP_W'(WDAY_RECIP);
  end

  // Cycle number and weekday, each with one correction step.
  always_comb begin
    cq0 = cprod_d[CYC_RK +: 6];
    cr0 = d_d - DAYS_W'(cq0) * CYC_DAYS;
    if (cr0 >= CYC_DAYS) begin
      cyc_next  = cq0 + 6'd1;
      crem_next = 11'(cr0 - CYC_DAYS);
    end else begin
      cyc_next  = cq0;
      crem_next = 11'(cr0);
    end
    wq0 = wprod_d[WDAY_RK +: 14];
    wr0 = w_d - DAYS_W'(wq0) * 16'd7;
    if (wr0 >= 16'd7) begin
      wday_next = WDAY_W'(wr0 - 16'd7);
    end else begin
      wday_next = WDAY_W'(wr0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_e <= 1'b0;
    end else begin
      valid_e <= valid_d;
    end
    cyc_e  <= cyc_next;
    crem_e <= crem_next;
    wday_e <= wday_next;
  end

  // Year within the cycle; the first year of each cycle is the leap year.
  always_comb begin
    if (crem_e < 11'd366) begin
      yo       = 2'd0;
      doy_next = DOY_W'(crem_e);
    end else if (crem_e < 11'd731) begin
      yo       = 2'd1;
      doy_next = DOY_W'(crem_e - 11'd366);
    end else if (crem_e < 11'd1096) begin
      yo       = 2'd2;
      doy_next = DOY_W'(crem_e - 11'd731);
    end else begin
      yo       = 2'd3;
      doy_next = DOY_W'(crem_e - 11'd1096);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_f <= 1'b0;
    end else begin
      valid_f <= valid_e;
    end
    year_f <= CYC_YEAR0 + {4'd0, cyc_e, 2'd0} + YEAR_W'(yo);
    leap_f <= (yo == 2'd0);
    doy_f  <= doy_next;
    wday_f <= wday_e;
  end

  // Month index counts the month starts already passed.
  always_comb begin
    mi = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (doy_f >= month_start(leap_f, 4'(i))) begin
        mi = mi + 4'd1;
      end
    end
    dom_full = doy_f - month_start(leap_f, mi) + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid_f;
    end
    year         <= year_f;
    month        <= mi + 4'd1;
    day_of_month <= DOM_W'(dom_full);
    weekday      <= wday_f;
  end

endmodule

FILE: rtl/core/esc_time.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time of day stages
// Four stages that split the second of the day into hour, minute and second
// by reciprocal multiplies with a correction step after each.
// ----------------------------------------------------------------------------
module esc_time import esc_pkg::*; (
  input  logic              clk,
  input  logic [TOD_W-1:0]  tod,
  output logic [HOUR_W-1:0] hours,
  output logic [MIN_W-1:0]  minutes,
  output logic [MIN_W-1:0]  seconds
);

  localparam int HP_W = TOD_W + 18;
  localparam int MP_W = 12 + 13;

  logic [TOD_W-1:0]  tod_d;
  logic [HP_W-1:0]   hprod_d;
  logic [5:0]        hq0;
  logic [TOD_W-1:0]  hr0;
  logic [HOUR_W-1:0] hour_next;
  logic [11:0]       hrem_next;
  logic [HOUR_W-1:0] hour_e;
  logic [11:0]       hrem_e;
  logic [HOUR_W-1:0] hour_f;
  logic [11:0]       hrem_f;
  logic [MP_W-1:0]   mprod_f;
  logic [6:0]        mq0;
  logic [11:0]       mr0;
  logic [MIN_W-1:0]  min_next;
  logic [MIN_W-1:0]  sec_next;

  // Hour estimate.
  always_ff @(posedge clk) begin
    tod_d   <= tod;
    hprod_d <= HP_W'(tod) * HP_W'(HOUR_RECIP);
  end

  always_comb begin
    hq0 = hprod_d[HOUR_RK +: 6];
    hr0 = tod_d - TOD_W'(hq0) * TOD_W'(SECS_HOUR);
    if (hr0 >= TOD_W'(SECS_HOUR)) begin
      hour_next = HOUR_W'(hq0 + 6'd1);
      hrem_next = 12'(hr0 - TOD_W'(SECS_HOUR));
    end else begin
      hour_next = HOUR_W'(hq0);
      hrem_next = 12'(hr0);
    end
  end

  always_ff @(posedge clk) begin
    hour_e <= hour_next;
    hrem_e <= hrem_next;
  end

  // Minute estimate from the seconds left in the hour.
  always_ff @(posedge clk) begin
    hour_f  <= hour_e;
    hrem_f  <= hrem_e;
    mprod_f <= MP_W'(hrem_e) * MP_W'(MIN_RECIP);
  end

  always_comb begin
    mq0 = mprod_f[MIN_RK +: 7];
    mr0 = hrem_f - 12'(mq0) * 12'(SECS_MIN);
    if (mr0 >= 12'(SECS_MIN)) begin
      min_next = MIN_W'(mq0 + 7'd1);
      sec_next = MIN_W'(mr0 - 12'(SECS_MIN));
    end else begin
      min_next = MIN_W'(mq0);
      sec_next = MIN_W'(mr0);
    end
  end

  always_ff @(posedge clk) begin
    hours   <= hour_f;
    minutes <= min_next;
    seconds <= sec_next;
  end

endmodule

FILE: tb/epoch_seconds_to_calendar_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch to calendar converter test
// Drives seconds counts into the converter and compares every date, time and
// weekday result against a behavioral calendar computed in the bench.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_test;
  import esc_pkg::*;

  typedef struct packed {
    logic [YEAR_W-1:0]  yr;
    logic [MONTH_W-1:0] mon;
    logic [DOM_W-1:0]   dom;
    logic [HOUR_W-1:0]  hr;
    logic [MIN_W-1:0]   mi;
    logic [MIN_W-1:0]   se;
    logic [WDAY_W-1:0]  wd;
  } civil_time_t;

  localparam int CYCLE_LIMIT = 400000;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [SECS_W-1:0]  epoch_seconds;
  logic               strobe;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DOM_W-1:0]   day_of_month;
  logic [HOUR_W-1:0]  hours;
  logic [MIN_W-1:0]   minutes;
  logic [MIN_W-1:0]   seconds;
  logic [WDAY_W-1:0]  weekday;

  civil_time_t pending_dates[$];
  int          mismatch_count;
  int          request_count;
  int          result_count;
  int          cycle_count;
  int          gap_pct;

  epoch_seconds_to_calendar i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .epoch_seconds(epoch_seconds), .strobe(strobe), .year(year),
    .month(month), .day_of_month(day_of_month), .hours(hours),
    .minutes(minutes), .seconds(seconds), .weekday(weekday)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic bit is_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Walks years and then months from the start of 1970.
  function automatic civil_time_t calendar_of(logic [31:0] secs);
    int unsigned days;
    int unsigned tod;
    int unsigned y;
    int unsigned m;
    int unsigned len;
    int unsigned mlen[12];
    civil_time_t r;
    mlen = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    days = secs / 86400;
    tod = secs % 86400;
    r.wd = WDAY_W'((days + 4) % 7);
    y = 1970;
    forever begin
      len = is_leap(y) ? 366 : 365;
      if (days < len) break;
      days -= len;
      y++;
    end
    m = 0;
    while (m < 11) begin
      len = (m == 1 && is_leap(y)) ? 29 : mlen[m];
      if (days < len) break;
      days -= len;
      m++;
    end
    r.yr = YEAR_W'(y);
    r.mon = MONTH_W'(m + 1);
    r.dom = DOM_W'(days + 1);
    r.hr = HOUR_W'(tod / 3600);
    r.mi = MIN_W'((tod % 3600) / 60);
    r.se = MIN_W'(tod % 60);
    return r;
  endfunction

  // Sends one request, with a random idle gap in front of it.
  task automatic send_request(logic [31:0] secs);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    epoch_seconds <= secs;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_dates.push_back(calendar_of(secs));
    request_count++;
  endtask

  // Stops sending and waits until every expected result has come.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  // Timestamps around known boundaries.
  task automatic test_directed();
    logic [31:0] points[$];
    points = '{32'd0, 32'd59, 32'd3599, 32'd86399, 32'd86400,
               32'd94694399,  // last second of 1972, a leap year
               32'd94608000,  // 1972-12-31, leap year last day
               32'd951782400, // 2000-02-29
               32'd951868800, // 2000-03-01
               32'd978307199, 32'd4107542400, // 2100-03-01
               32'd4107455999, 32'd4102444800, // 2100-01-01
               32'h7FFFFFFF, 32'h80000000, 32'hAAAAAAAA, 32'h55555555,
               32'hFFFFFFFE, 32'hFFFFFFFF};
    foreach (points[i]) send_request(points[i]);
  endtask

  // Half uniform values, the rest picked near midnight.
  task automatic test_random(int count);
    logic [31:0] secs;
    repeat (count) begin
      case ($urandom_range(3))
        0: secs = $urandom_range(4, 0) * 32'd86400 + $urandom_range(2) - 1;
        1: secs = $urandom_range(49709) * 32'd86400 + $urandom_range(5);
        default: secs = $urandom;
      endcase
      send_request(secs);
    end
  endtask

  // Compares each result with the oldest pending request.
  always @(posedge clk) begin
    civil_time_t exp_date;
    civil_time_t got_date;
    if (!rst && strobe) begin
      got_date = '{year, month, day_of_month, hours, minutes, seconds, weekday};
      result_count++;
      if (pending_dates.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", got_date);
      end else begin
        exp_date = pending_dates.pop_front();
        if (got_date !== exp_date) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %p actual %p", exp_date, got_date);
        end
      end
    end
  end

  // Ends the run if the converter stops answering.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("epoch_seconds_to_calendar_test: errors");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    request_count = 0;
    result_count = 0;
    cycle_count = 0;
    gap_pct = 13;
    rst <= 1'b1;
    start <= 1'b0;
    epoch_seconds <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    drain_results();
    test_random(500);
    drain_results();
    gap_pct = 61;
    test_random(500);
    gap_pct = 0;
    test_random(530);
    drain_results();
    repeat (20) @(posedge clk);
    $display("Converted %0d timestamps from 1970 through 2106, %0d results checked.",
             request_count, result_count);
    if (mismatch_count == 0 && pending_dates.size() == 0) begin
      $display("epoch_seconds_to_calendar_test: clean");
    end else begin
      $display("epoch_seconds_to_calendar_test: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/esc_pkg.sv
rtl/core/esc_day_split.sv
rtl/core/esc_date.sv
rtl/core/esc_time.sv
rtl/core/epoch_seconds_to_calendar.sv
tb/epoch_seconds_to_calendar_test.sv
